>>> hw/rtl/adsr_envelope_gain_top_defines.svh
// Assertion macros shared by the envelope gain RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ADSR_ENVELOPE_GAIN_TOP_DEFINES_SVH
`define ADSR_ENVELOPE_GAIN_TOP_DEFINES_SVH

// same-cycle implication
`define ADSR_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adsr: assertion failed");

// implication with a fixed delay in cycles
`define ADSR_ASSERT_DLY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
    else $error("adsr: delayed assertion failed");

`endif

>>> hw/rtl/adsr_pkg.sv
// Types and constants for the ADSR envelope gain block.
// No dependencies; used by adsr_div and adsr_envelope_gain_top.
package adsr_pkg;

  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int PCT_W    = 7;
  localparam int PHASE_W  = 3;
  localparam int GAIN_W   = 17;   // Q0.16 with room for unity
  localparam int QUO_W    = 16;   // segment gains always stay below unity

  localparam logic [PCT_W-1:0]  PCT_FULL = 7'd100;
  localparam logic [GAIN_W-1:0] UNITY    = 17'h10000;

  // floor(pct * 65536 / 100) == (pct * SUS_RECIP) >> SUS_SHIFT for pct <= 100
  localparam logic [19:0] SUS_RECIP = 20'd671089;
  localparam int          SUS_SHIFT = 10;

  typedef logic [GAIN_W-1:0] gain_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_OFF,
    PH_ATTACK,
    PH_DECAY,
    PH_SUSTAIN,
    PH_RELEASE
  } phase_t;

  typedef enum logic [2:0] {
    REG_NOTE_START,
    REG_ATTACK_END,
    REG_DECAY_END,
    REG_RELEASE_START,
    REG_NOTE_END,
    REG_SUSTAIN_PCT
  } reg_idx_t;

  // sustain gain from a raw percent value, saturated at full scale
  function automatic gain_t sus_gain(input logic [PCT_W-1:0] pct);
    logic [PCT_W-1:0] sat;
    logic [26:0]      prod;
    sat  = (pct > PCT_FULL) ? PCT_FULL : pct;
    prod = 27'(sat) * 27'(SUS_RECIP);
    return prod[SUS_SHIFT +: GAIN_W];
  endfunction

endpackage

>>> hw/rtl/adsr_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on adsr_pkg and adsr_envelope_gain_top_defines.svh.
`include "adsr_envelope_gain_top_defines.svh"

module adsr_div #(
  parameter int NUM_W  = 39,
  parameter int DEN_W  = 22,
  parameter int SIDE_W = 35
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [NUM_W-1:0]                in_num,
  input  logic [DEN_W-1:0]                in_den,
  input  logic [SIDE_W-1:0]               in_side,
  output logic                            out_valid,
  output logic [adsr_pkg::QUO_W-1:0]      out_quo,
  output logic [SIDE_W-1:0]               out_side
);
  import adsr_pkg::*;

  // caller guarantees in_num < in_den * 2**QUO_W
  logic                vld_r  [QUO_W];
  logic [NUM_W-1:0]    rem_r  [QUO_W];
  logic [DEN_W-1:0]    den_r  [QUO_W];
  logic [QUO_W-1:0]    quo_r  [QUO_W];
  logic [SIDE_W-1:0]   side_r [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int K = QUO_W - 1 - s;
    logic              vld_in;
    logic [NUM_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [QUO_W-1:0]  quo_in;
    logic [SIDE_W-1:0] side_in;
    logic [NUM_W-1:0]  dsh;
    logic              ge;
    logic [NUM_W-1:0]  rem_nxt;

    if (s == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign den_in  = den_r[s-1];
      assign quo_in  = quo_r[s-1];
      assign side_in = side_r[s-1];
    end

    assign dsh     = NUM_W'(den_in) << K;
    assign ge      = (rem_in >= dsh);
    assign rem_nxt = ge ? (rem_in - dsh) : rem_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= rem_nxt;
      den_r[s]  <= den_in;
      quo_r[s]  <= {quo_in[QUO_W-2:0], ge};
      side_r[s] <= side_in;
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_quo   = quo_r[QUO_W-1];
  assign out_side  = side_r[QUO_W-1];

  `ADSR_ASSERT(a_div_rem_below_den, out_valid, rem_r[QUO_W-1] < NUM_W'(den_r[QUO_W-1]))
  `ADSR_ASSERT_DLY(a_div_latency, in_valid, QUO_W, out_valid)
  `ADSR_ASSERT(a_div_side_kept, out_valid, out_side == $past(in_side, QUO_W))

endmodule

>>> hw/rtl/adsr_envelope_gain_top.sv
// Linear ADSR envelope gain: top level with register file and pipeline.
// Depends on adsr_pkg, adsr_div and adsr_envelope_gain_top_defines.svh.
//
// One stereo pair is taken on every cycle that start is high; busy never
// rises. Each result appears on out_* for a single cycle with out_strobe high,
// after three decode/multiply stages, the 16-stage gain divider, then gain
// select, sample multiply and output register. Results come out in request
// order and cannot be held off, so the receiver must take out_* whenever
// out_strobe is high. The user must write boundary and sustain registers over
// the APB port only while no request is in flight; the block itself does not
// enforce this; boundaries are expected in ascending order.
`include "adsr_envelope_gain_top_defines.svh"

module adsr_envelope_gain_top #(
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 22
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [INDEX_BITS-1:0]              in_sample_index,
  input  logic signed [SAMPLE_BITS-1:0]      in_left_in,
  input  logic signed [SAMPLE_BITS-1:0]      in_right_in,
  output logic                               out_strobe,
  output logic signed [SAMPLE_BITS-1:0]      out_left_out,
  output logic signed [SAMPLE_BITS-1:0]      out_right_out,
  output logic [adsr_pkg::PHASE_W-1:0]       out_envelope_phase,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [adsr_pkg::ADDR_W-1:0]        paddr,
  input  logic [adsr_pkg::DATA_W-1:0]        pwdata,
  output logic [adsr_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import adsr_pkg::*;

  localparam int NUM_W  = INDEX_BITS + GAIN_W;
  localparam int SIDE_W = 2 * SAMPLE_BITS + PHASE_W;
  localparam int PROD_W = SAMPLE_BITS + GAIN_W;
  localparam int LAT    = QUO_W + 6;

  // ---------------- register file ----------------
  logic [INDEX_BITS-1:0] ns_r, ae_r, de_r, rs_r, ne_r;
  logic [PCT_W-1:0]      pct_r;
  gain_t                 sus_r;
  logic                  wr_en;
  reg_idx_t              ridx;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite;
  assign ridx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_r  <= '0;
      ae_r  <= '0;
      de_r  <= '0;
      rs_r  <= '0;
      ne_r  <= '0;
      pct_r <= PCT_FULL;
      sus_r <= UNITY;
    end else if (wr_en) begin
      case (ridx)
        REG_NOTE_START:    ns_r <= pwdata[INDEX_BITS-1:0];
        REG_ATTACK_END:    ae_r <= pwdata[INDEX_BITS-1:0];
        REG_DECAY_END:     de_r <= pwdata[INDEX_BITS-1:0];
        REG_RELEASE_START: rs_r <= pwdata[INDEX_BITS-1:0];
        REG_NOTE_END:      ne_r <= pwdata[INDEX_BITS-1:0];
        REG_SUSTAIN_PCT: begin
          pct_r <= pwdata[PCT_W-1:0];
          sus_r <= sus_gain(pwdata[PCT_W-1:0]);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_NOTE_START:    prdata = DATA_W'(ns_r);
      REG_ATTACK_END:    prdata = DATA_W'(ae_r);
      REG_DECAY_END:     prdata = DATA_W'(de_r);
      REG_RELEASE_START: prdata = DATA_W'(rs_r);
      REG_NOTE_END:      prdata = DATA_W'(ne_r);
      REG_SUSTAIN_PCT:   prdata = DATA_W'(pct_r);
      default:           prdata = '0;
    endcase
  end

  // ---------------- stage 1: phase decode ----------------
  phase_t                 s1_ph_nxt, s1_ph_r;
  logic                   s1_v_r;
  logic [INDEX_BITS-1:0]  s1_idx_r;
  logic [SAMPLE_BITS-1:0] s1_l_r, s1_rt_r;

  // first matching segment wins
  always_comb begin
    if (ns_r <= in_sample_index && in_sample_index < ae_r) begin
      s1_ph_nxt = PH_ATTACK;
    end else if (ae_r <= in_sample_index && in_sample_index < de_r) begin
      s1_ph_nxt = PH_DECAY;
    end else if (de_r <= in_sample_index && in_sample_index < rs_r) begin
      s1_ph_nxt = PH_SUSTAIN;
    end else if (rs_r <= in_sample_index && in_sample_index < ne_r) begin
      s1_ph_nxt = PH_RELEASE;
    end else begin
      s1_ph_nxt = PH_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_ph_r  <= s1_ph_nxt;
    s1_idx_r <= in_sample_index;
    s1_l_r   <= in_left_in;
    s1_rt_r  <= in_right_in;
  end

  // ---------------- stage 2: segment offset, length, slope factor ------
  logic [INDEX_BITS-1:0]  s2_off_nxt, s2_len_nxt, s2_off_r, s2_len_r;
  gain_t                  s2_fac_nxt, s2_fac_r;
  logic                   s2_v_r;
  phase_t                 s2_ph_r;
  logic [SAMPLE_BITS-1:0] s2_l_r, s2_rt_r;

  always_comb begin
    case (s1_ph_r)
      PH_ATTACK: begin
        s2_off_nxt = s1_idx_r - ns_r;
        s2_len_nxt = ae_r - ns_r;
        s2_fac_nxt = UNITY;
      end
      PH_DECAY: begin
        s2_off_nxt = s1_idx_r - ae_r;
        s2_len_nxt = de_r - ae_r;
        s2_fac_nxt = UNITY - sus_r;
      end
      PH_RELEASE: begin
        s2_off_nxt = s1_idx_r - rs_r;
        s2_len_nxt = ne_r - rs_r;
        s2_fac_nxt = sus_r;
      end
      default: begin
        // flat gain: feed the divider 0 / 1
        s2_off_nxt = '0;
        s2_len_nxt = INDEX_BITS'(1);
        s2_fac_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_off_r <= s2_off_nxt;
    s2_len_r <= s2_len_nxt;
    s2_fac_r <= s2_fac_nxt;
    s2_ph_r  <= s1_ph_r;
    s2_l_r   <= s1_l_r;
    s2_rt_r  <= s1_rt_r;
  end

  // ---------------- stage 3: numerator multiply ----------------
  logic [NUM_W-1:0]      s3_num_nxt, s3_num_r;
  logic [INDEX_BITS-1:0] s3_len_r;
  logic [SIDE_W-1:0]     s3_side_r;
  logic                  s3_v_r;

  assign s3_num_nxt = NUM_W'(s2_off_r) * NUM_W'(s2_fac_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_num_r  <= s3_num_nxt;
    s3_len_r  <= s2_len_r;
    s3_side_r <= {s2_l_r, s2_rt_r, s2_ph_r};
  end

  // ---------------- divider ----------------
  logic              dv_valid;
  logic [QUO_W-1:0]  dv_quo;
  logic [SIDE_W-1:0] dv_side;

  adsr_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (INDEX_BITS),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_v_r),
    .in_num    (s3_num_r),
    .in_den    (s3_len_r),
    .in_side   (s3_side_r),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // ---------------- gain select and sample magnitude ----------------
  logic [SAMPLE_BITS-1:0] dv_l, dv_rt;
  phase_t                 dv_ph;
  gain_t                  g_gain_nxt, g_gain_r;
  gain_t                  dv_q;
  logic                   g_v_r;
  phase_t                 g_ph_r;
  logic [SAMPLE_BITS-1:0] g_lmag_r, g_rmag_r;
  logic                   g_lneg_r, g_rneg_r;

  assign dv_l  = dv_side[SIDE_W-1 -: SAMPLE_BITS];
  assign dv_rt = dv_side[PHASE_W +: SAMPLE_BITS];
  assign dv_ph = phase_t'(dv_side[PHASE_W-1:0]);
  assign dv_q  = GAIN_W'(dv_quo);

  always_comb begin
    case (dv_ph)
      PH_ATTACK:  g_gain_nxt = dv_q;
      PH_DECAY:   g_gain_nxt = UNITY - dv_q;
      PH_SUSTAIN: g_gain_nxt = sus_r;
      PH_RELEASE: g_gain_nxt = sus_r - dv_q;
      default:    g_gain_nxt = UNITY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else begin
      g_v_r <= dv_valid;
    end
  end

  // magnitude of the most negative sample still fits SAMPLE_BITS unsigned
  always_ff @(posedge clk) begin
    g_gain_r <= g_gain_nxt;
    g_ph_r   <= dv_ph;
    g_lneg_r <= dv_l[SAMPLE_BITS-1];
    g_rneg_r <= dv_rt[SAMPLE_BITS-1];
    g_lmag_r <= dv_l[SAMPLE_BITS-1] ? (~dv_l + 1'b1) : dv_l;
    g_rmag_r <= dv_rt[SAMPLE_BITS-1] ? (~dv_rt + 1'b1) : dv_rt;
  end

  // ---------------- sample multiply ----------------
  logic [PROD_W-1:0] m_lp_r, m_rp_r;
  logic              m_v_r, m_lneg_r, m_rneg_r;
  phase_t            m_ph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else begin
      m_v_r <= g_v_r;
    end
  end

  always_ff @(posedge clk) begin
    m_lp_r   <= PROD_W'(g_lmag_r) * PROD_W'(g_gain_r);
    m_rp_r   <= PROD_W'(g_rmag_r) * PROD_W'(g_gain_r);
    m_lneg_r <= g_lneg_r;
    m_rneg_r <= g_rneg_r;
    m_ph_r   <= g_ph_r;
  end

  // ---------------- output: drop fraction, restore sign ----------------
  logic [SAMPLE_BITS-1:0] o_lmag, o_rmag;

  assign o_lmag = m_lp_r[16 +: SAMPLE_BITS];
  assign o_rmag = m_rp_r[16 +: SAMPLE_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_left_out       <= m_lneg_r ? (~o_lmag + 1'b1) : o_lmag;
    out_right_out      <= m_rneg_r ? (~o_rmag + 1'b1) : o_rmag;
    out_envelope_phase <= m_ph_r;
  end

  `ADSR_ASSERT_DLY(a_request_latency, start && !busy, LAT, out_strobe)
  `ADSR_ASSERT(a_gain_in_range, g_v_r, g_gain_r <= UNITY)
  `ADSR_ASSERT(a_off_note_passthru, out_strobe && out_envelope_phase == PH_OFF,
               (out_left_out == $past(in_left_in, LAT)) &&
               (out_right_out == $past(in_right_in, LAT)))

endmodule

>>> test/envelope_monitor.sv
// Watches the request, result and APB channels of adsr_envelope_gain_top,
// predicts each stereo result from a shadow of the envelope registers and compares.
// Depends on adsr_pkg for the phase and register index codes.
`timescale 1ns / 1ps

module envelope_monitor #(
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 22
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [INDEX_BITS-1:0]         in_sample_index,
  input  logic signed [SAMPLE_BITS-1:0] in_left_in,
  input  logic signed [SAMPLE_BITS-1:0] in_right_in,
  input  logic                          out_strobe,
  input  logic signed [SAMPLE_BITS-1:0] out_left_out,
  input  logic signed [SAMPLE_BITS-1:0] out_right_out,
  input  logic [adsr_pkg::PHASE_W-1:0]  out_envelope_phase,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [adsr_pkg::ADDR_W-1:0]   paddr,
  input  logic [adsr_pkg::DATA_W-1:0]   pwdata,
  input  logic                          pready,
  output int                            mismatches,
  output int                            in_flight
);
  import adsr_pkg::*;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
    phase_t                 phase;
  } stereo_out_t;

  stereo_out_t expected_pairs [$];
  int          fail_count = 0;

  logic [INDEX_BITS-1:0] note_start_q;
  logic [INDEX_BITS-1:0] attack_end_q;
  logic [INDEX_BITS-1:0] decay_end_q;
  logic [INDEX_BITS-1:0] release_start_q;
  logic [INDEX_BITS-1:0] note_end_q;
  logic [PCT_W-1:0]      sustain_pct_q;

  assign mismatches = fail_count;

  // magnitude times gain, shifted down, sign restored: truncates toward zero
  function automatic logic [SAMPLE_BITS-1:0] scale_sample(input logic [SAMPLE_BITS-1:0] s,
                                                          input longint unsigned gain);
    longint unsigned mag;
    longint unsigned p;
    mag = s;
    if (s[SAMPLE_BITS-1])
      mag = (64'd1 << SAMPLE_BITS) - mag;
    p = (mag * gain) >> 16;
    if (s[SAMPLE_BITS-1])
      p = -p;
    return p[SAMPLE_BITS-1:0];
  endfunction

  function automatic stereo_out_t predict_pair(input logic [INDEX_BITS-1:0] idx,
                                               input logic [SAMPLE_BITS-1:0] l,
                                               input logic [SAMPLE_BITS-1:0] r);
    longint unsigned i, ns, ae, de, rs, ne, pct, sus, gain;
    stereo_out_t res;
    i   = idx;
    ns  = note_start_q;
    ae  = attack_end_q;
    de  = decay_end_q;
    rs  = release_start_q;
    ne  = note_end_q;
    pct = (sustain_pct_q > PCT_FULL) ? PCT_FULL : sustain_pct_q;
    sus = (pct * UNITY) / PCT_FULL;
    gain = UNITY;
    res.phase = PH_OFF;
    // first matching segment wins; an empty segment never matches
    if (ns <= i && i < ae) begin
      res.phase = PH_ATTACK;
      gain = ((i - ns) << 16) / (ae - ns);
    end else if (ae <= i && i < de) begin
      res.phase = PH_DECAY;
      gain = UNITY - ((i - ae) * (UNITY - sus)) / (de - ae);
    end else if (de <= i && i < rs) begin
      res.phase = PH_SUSTAIN;
      gain = sus;
    end else if (rs <= i && i < ne) begin
      res.phase = PH_RELEASE;
      gain = sus - ((i - rs) * sus) / (ne - rs);
    end
    res.left  = scale_sample(l, gain);
    res.right = scale_sample(r, gain);
    return res;
  endfunction

  always @(posedge clk) begin
    stereo_out_t want;
    if (!rst_n) begin
      note_start_q    <= '0;
      attack_end_q    <= '0;
      decay_end_q     <= '0;
      release_start_q <= '0;
      note_end_q      <= '0;
      sustain_pct_q   <= PCT_FULL;
      expected_pairs.delete();
    end else begin
      if (start && !busy)
        expected_pairs.push_back(predict_pair(in_sample_index, in_left_in, in_right_in));

      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_NOTE_START:    note_start_q    <= pwdata[INDEX_BITS-1:0];
          REG_ATTACK_END:    attack_end_q    <= pwdata[INDEX_BITS-1:0];
          REG_DECAY_END:     decay_end_q     <= pwdata[INDEX_BITS-1:0];
          REG_RELEASE_START: release_start_q <= pwdata[INDEX_BITS-1:0];
          REG_NOTE_END:      note_end_q      <= pwdata[INDEX_BITS-1:0];
          REG_SUSTAIN_PCT:   sustain_pct_q   <= pwdata[PCT_W-1:0];
          default: ;
        endcase
      end

      if (out_strobe === 1'b1) begin
        if (expected_pairs.size() == 0) begin
          $error("result with no request waiting: left %0d right %0d phase %0d",
                 out_left_out, out_right_out, out_envelope_phase);
          fail_count++;
        end else begin
          want = expected_pairs.pop_front();
          if (out_left_out !== want.left) begin
            $error("left_out: expected %0d, got %0d", $signed(want.left), out_left_out);
            fail_count++;
          end
          if (out_right_out !== want.right) begin
            $error("right_out: expected %0d, got %0d", $signed(want.right), out_right_out);
            fail_count++;
          end
          if (out_envelope_phase !== want.phase) begin
            $error("envelope_phase: expected %0d, got %0d", want.phase, out_envelope_phase);
            fail_count++;
          end
        end
      end
    end
    in_flight = expected_pairs.size();
  end

endmodule

>>> test/testbench.sv
// Stimulus and verdict for adsr_envelope_gain_top: directed envelope corners, then
// random envelopes with bursty requests. Depends on adsr_pkg and envelope_monitor.
`timescale 1ns / 1ps

module testbench;
  import adsr_pkg::*;

  localparam int SAMPLE_BITS = 16;
  localparam int INDEX_BITS  = 22;
  localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

  typedef enum int {
    SHAPE_SHORT,
    SHAPE_WIDE,
    SHAPE_TOP,
    SHAPE_SCRAMBLED
  } envelope_shape_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [INDEX_BITS-1:0]         in_sample_index;
  logic signed [SAMPLE_BITS-1:0] in_left_in;
  logic signed [SAMPLE_BITS-1:0] in_right_in;
  logic                          out_strobe;
  logic signed [SAMPLE_BITS-1:0] out_left_out;
  logic signed [SAMPLE_BITS-1:0] out_right_out;
  logic [PHASE_W-1:0]            out_envelope_phase;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [ADDR_W-1:0]             paddr;
  logic [DATA_W-1:0]             pwdata;
  logic [DATA_W-1:0]             prdata;
  logic                          pready;
  int                            mismatches;
  int                            in_flight;

  // boundaries in register order: note_start .. note_end
  logic [INDEX_BITS-1:0] env_bnd [5];

  always #10 clk = ~clk;

  adsr_envelope_gain_top #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_sample_index   (in_sample_index),
    .in_left_in        (in_left_in),
    .in_right_in       (in_right_in),
    .out_strobe        (out_strobe),
    .out_left_out      (out_left_out),
    .out_right_out     (out_right_out),
    .out_envelope_phase(out_envelope_phase),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  envelope_monitor #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) envelope_mon (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_sample_index   (in_sample_index),
    .in_left_in        (in_left_in),
    .in_right_in       (in_right_in),
    .out_strobe        (out_strobe),
    .out_left_out      (out_left_out),
    .out_right_out     (out_right_out),
    .out_envelope_phase(out_envelope_phase),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .mismatches        (mismatches),
    .in_flight         (in_flight)
  );

  function automatic logic [INDEX_BITS-1:0] clamp_index(input longint v);
    if (v < 0)
      return '0;
    if (v > IDX_MAX)
      return IDX_MAX;
    return v[INDEX_BITS-1:0];
  endfunction

  task automatic write_reg(input reg_idx_t r, input logic [DATA_W-1:0] v);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'({r, 2'b00});
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic write_envelope(input logic [PCT_W-1:0] pct);
    write_reg(REG_NOTE_START,    DATA_W'(env_bnd[0]));
    write_reg(REG_ATTACK_END,    DATA_W'(env_bnd[1]));
    write_reg(REG_DECAY_END,     DATA_W'(env_bnd[2]));
    write_reg(REG_RELEASE_START, DATA_W'(env_bnd[3]));
    write_reg(REG_NOTE_END,      DATA_W'(env_bnd[4]));
    write_reg(REG_SUSTAIN_PCT,   DATA_W'(pct));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic shape_envelope(input envelope_shape_t shape);
    longint acc;
    int     k;
    case (shape)
      SHAPE_SHORT: begin
        acc = $urandom_range(0, IDX_MAX - 300);
        for (k = 0; k < 5; k++) begin
          env_bnd[k] = clamp_index(acc);
          acc += ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 64);
        end
      end
      SHAPE_WIDE: begin
        // long segments stress the divider with large numerators
        acc = $urandom_range(0, 1) ? 0 : $urandom_range(0, 4095);
        for (k = 0; k < 5; k++) begin
          env_bnd[k] = clamp_index(acc);
          acc += $urandom_range(0, 1048575);
        end
      end
      SHAPE_TOP: begin
        acc = IDX_MAX;
        for (k = 4; k >= 0; k--) begin
          env_bnd[k] = clamp_index(acc);
          acc -= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 64);
        end
      end
      default: begin
        // boundaries in any order
        acc = $urandom_range(0, IDX_MAX - 100);
        for (k = 0; k < 5; k++)
          env_bnd[k] = clamp_index(acc + $urandom_range(0, 80));
      end
    endcase
  endtask

  function automatic logic [INDEX_BITS-1:0] pick_index();
    int     sel;
    int     k;
    longint lo;
    longint hi;
    sel = $urandom_range(0, 19);
    lo  = env_bnd[0];
    hi  = env_bnd[0];
    for (k = 1; k < 5; k++) begin
      if (env_bnd[k] < lo) lo = env_bnd[k];
      if (env_bnd[k] > hi) hi = env_bnd[k];
    end
    if (sel < 10)
      return clamp_index(longint'(env_bnd[$urandom_range(0, 4)]) + $urandom_range(0, 8) - 4);
    if (sel < 16)
      return clamp_index(lo + $urandom_range(0, int'(hi - lo)));
    if (sel < 19)
      return INDEX_BITS'($urandom);
    return $urandom_range(0, 1) ? IDX_MAX : '0;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_level();
    if ($urandom_range(0, 3) != 0)
      return SAMPLE_BITS'($urandom);
    case ($urandom_range(0, 4))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  // start stays high into the next request when no gap follows
  task automatic send_pair(input logic [INDEX_BITS-1:0] idx,
                           input logic [SAMPLE_BITS-1:0] l,
                           input logic [SAMPLE_BITS-1:0] r);
    @(negedge clk);
    start           = 1'b1;
    in_sample_index = idx;
    in_left_in      = l;
    in_right_in     = r;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (in_flight != 0)
      @(negedge clk);
  endtask

  initial begin
    int               ph;
    int               n;
    int               burst_left;
    logic [PCT_W-1:0] pct;

    rst_n           = 1'b0;
    start           = 1'b0;
    in_sample_index = '0;
    in_left_in      = '0;
    in_right_in     = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    burst_left      = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // reset values: every sample lies outside the note
    send_pair(0, 16'h7FFF, 16'h8000);
    send_pair(IDX_MAX, 16'hFFFF, 16'h0001);

    // every phase and every boundary of a short envelope, half sustain
    wait_idle();
    env_bnd[0] = 10;
    env_bnd[1] = 20;
    env_bnd[2] = 30;
    env_bnd[3] = 40;
    env_bnd[4] = 50;
    write_envelope(7'd50);
    send_pair(0,       16'h7FFF, 16'h8000);
    send_pair(9,       16'h1234, 16'hEDCB);
    send_pair(10,      16'h7FFF, 16'h8000);
    send_pair(15,      16'h7FFF, 16'h8000);
    send_pair(19,      16'h8000, 16'h7FFF);
    send_pair(20,      16'h7FFF, 16'h8000);
    send_pair(25,      16'hFFFF, 16'h0001);
    send_pair(29,      16'h7FFF, 16'h8000);
    send_pair(30,      16'h7FFF, 16'h8000);
    send_pair(39,      16'h8000, 16'h0000);
    send_pair(40,      16'h7FFF, 16'h8000);
    send_pair(45,      16'h0001, 16'hFFFF);
    send_pair(49,      16'h7FFF, 16'h8000);
    send_pair(50,      16'h7FFF, 16'h8000);
    send_pair(IDX_MAX, 16'h8000, 16'h7FFF);

    // empty attack, release reaching the top index, sustain above full scale
    wait_idle();
    env_bnd[0] = 0;
    env_bnd[1] = 0;
    env_bnd[2] = 4;
    env_bnd[3] = 8;
    env_bnd[4] = IDX_MAX;
    write_envelope(7'd127);
    send_pair(0,              16'h7FFF, 16'h8000);
    send_pair(3,              16'h8000, 16'h7FFF);
    send_pair(4,              16'h7FFF, 16'h8000);
    send_pair(8,              16'h7FFF, 16'h8000);
    send_pair(IDX_MAX - 1'b1, 16'h7FFF, 16'h8000);
    send_pair(IDX_MAX,        16'h8000, 16'hFFFF);

    for (ph = 0; ph < 9; ph++) begin
      wait_idle();
      shape_envelope(envelope_shape_t'(ph % 4));
      case (ph)
        0:       pct = 7'd0;
        1:       pct = PCT_FULL;
        2:       pct = 7'd127;
        default: pct = PCT_W'($urandom_range(0, 127));
      endcase
      write_envelope(pct);
      for (n = 0; n < 50; n++) begin
        if (burst_left == 0) begin
          idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
          burst_left = $urandom_range(1, 24);
        end
        send_pair(pick_index(), pick_level(), pick_level());
        burst_left--;
      end
    end

    wait_idle();
    repeat (30) @(negedge clk);
    if (mismatches == 0)
      $display("** adsr_envelope_gain_top: PASSED **");
    else
      $display("** adsr_envelope_gain_top: FAILED **");
    $finish;
  end

  initial begin
    #4000000;
    $display("** adsr_envelope_gain_top: FAILED **");
    $finish;
  end

endmodule
